@@ design/irrigation_pump_controller_defines.svh @@
// assertion macros for the irrigation pump controller checker
// no dependencies; included by the checker file only
`ifndef IRRIGATION_PUMP_CONTROLLER_DEFINES_SVH
`define IRRIGATION_PUMP_CONTROLLER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define IPC_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("irrigation pump controller check failed");

// next-cycle implication, disabled while reset is asserted
`define IPC_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("irrigation pump controller check failed");

`endif

@@ design/ipc_pkg.sv @@
// shared types, codes and constants for the irrigation pump controller
// no dependencies; used by every other file of the block except the assertion macros header
package ipc_pkg;

    // default values of the top-level parameters
    localparam int SAMPLES_PER_CYCLE_DEF = 3;
    localparam int LEVEL_CONFIRM_DEF     = 5;
    localparam int DRY_CONFIRM_DEF       = 3;
    localparam int ADC_BITS_DEF          = 12;

    // sensor thresholds and scaling
    localparam int WATER_PRESENT_BELOW = 500;
    localparam int WATER_ABSENT_ABOVE  = 3500;
    localparam int SOIL_WET            = 1000;
    localparam int FULL_SCALE          = 25600;

    // field widths
    localparam int HUM_W      = 15;
    localparam int DUR_W      = 20;
    localparam int TMR_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // register reset values
    localparam logic [HUM_W-1:0] THRESHOLD_RST  = 15'd17920;
    localparam logic [DUR_W-1:0] DURATION_RST   = 20'd60000;
    localparam logic [TMR_W-1:0] CYCLE_RST      = 16'd30000;
    localparam logic [TMR_W-1:0] SAMPLE_RST     = 16'd2000;
    localparam logic [TMR_W-1:0] WARMUP_RST     = 16'd500;
    localparam logic [TMR_W-1:0] LEVEL_RST      = 16'd250;
    localparam logic [TMR_W-1:0] DEDUP_RST      = 16'd60000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUMIDITY_THRESHOLD = 3'd0,
        REG_PUMP_DURATION      = 3'd1,
        REG_CYCLE_INTERVAL     = 3'd2,
        REG_SAMPLE_INTERVAL    = 3'd3,
        REG_WARMUP             = 3'd4,
        REG_LEVEL_CHECK        = 3'd5,
        REG_EVENT_DEDUP        = 3'd6
    } reg_index_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PUMP_ON  = 3'd1,
        EV_BLOCKED  = 3'd2,
        EV_OFF_DRY  = 3'd3,
        EV_OFF_DONE = 3'd4
    } event_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_WARM   = 2'd1,
        PH_SAMPLE = 2'd2
    } phase_t;

    typedef struct packed {
        logic [HUM_W-1:0] humidity_threshold;
        logic [DUR_W-1:0] pump_duration_ms;
        logic [TMR_W-1:0] cycle_interval_ms;
        logic [TMR_W-1:0] sample_interval_ms;
        logic [TMR_W-1:0] warmup_ms;
        logic [TMR_W-1:0] level_check_ms;
        logic [TMR_W-1:0] event_holdoff_ms;
    } cfg_t;

    typedef struct packed {
        logic             pump_drive;
        logic             sensor_power;
        logic             water_ok;
        logic             watering_locked;
        event_t           event_code;
        logic             avg_valid;
        logic [HUM_W-1:0] humidity_avg;
    } result_t;

endpackage

@@ design/ipc_percent.sv @@
// soil reading to humidity percent times 256, clamped to full scale
// depends on ipc_pkg; division by the fixed span done as a reciprocal multiply
module ipc_percent #(
    parameter int ADC_BITS = ipc_pkg::ADC_BITS_DEF
) (
    input  logic [ADC_BITS-1:0]       soil,
    output logic [ipc_pkg::HUM_W-1:0] percent
);

    localparam int DRY   = (1 << ADC_BITS) - 1;
    localparam int SPAN  = (DRY > ipc_pkg::SOIL_WET) ? DRY - ipc_pkg::SOIL_WET : 1;
    localparam int SHIFT = 2 * ADC_BITS;
    // rounded-up reciprocal, exact for every distance below the span
    localparam longint unsigned MULT =
        ((longint'(ipc_pkg::FULL_SCALE) << SHIFT) + longint'(SPAN) - 1) / longint'(SPAN);
    localparam int MULT_W = $clog2(MULT + 1);
    localparam int PROD_W = ADC_BITS + MULT_W;

    logic [ADC_BITS-1:0] dry_gap;
    logic [PROD_W-1:0]   prod;

    assign dry_gap = ADC_BITS'(DRY) - soil;
    assign prod    = PROD_W'(dry_gap) * PROD_W'(MULT);

    always_comb
    begin
        if (32'(soil) >= DRY)
        begin
            percent = '0;
        end
        else if (32'(soil) <= ipc_pkg::SOIL_WET)
        begin
            percent = ipc_pkg::HUM_W'(ipc_pkg::FULL_SCALE);
        end
        else
        begin
            percent = prod[SHIFT +: ipc_pkg::HUM_W];
        end
    end

endmodule

@@ design/ipc_core.sv @@
// controller state and per-tick update: water confirm, pump run, sampling cycle
// depends on ipc_pkg; the step input advances the state by one tick
module ipc_core #(
    parameter int SAMPLES_PER_CYCLE = ipc_pkg::SAMPLES_PER_CYCLE_DEF,
    parameter int LEVEL_CONFIRM     = ipc_pkg::LEVEL_CONFIRM_DEF,
    parameter int DRY_CONFIRM       = ipc_pkg::DRY_CONFIRM_DEF,
    parameter int ADC_BITS          = ipc_pkg::ADC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  ipc_pkg::cfg_t             cfg,
    input  logic [ADC_BITS-1:0]       water,
    input  logic [ipc_pkg::HUM_W-1:0] percent,
    output ipc_pkg::result_t          result
);

    localparam int TW      = ipc_pkg::TMR_W;
    localparam int DW      = ipc_pkg::DUR_W;
    localparam int HW      = ipc_pkg::HUM_W;
    localparam int SC_W    = $clog2(SAMPLES_PER_CYCLE + 1);
    localparam int DRY_W   = $clog2(DRY_CONFIRM + 1);
    localparam int CONF_W  = $clog2(LEVEL_CONFIRM + 1) + 1;
    localparam int SUM_MAX = SAMPLES_PER_CYCLE * ipc_pkg::FULL_SCALE;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    localparam int AVG_SHIFT = $clog2(SUM_MAX * SAMPLES_PER_CYCLE + 1);
    localparam int AVG_MULT  = ((1 << AVG_SHIFT) + SAMPLES_PER_CYCLE - 1) / SAMPLES_PER_CYCLE;
    localparam int AVG_MW    = $clog2(AVG_MULT + 1);
    localparam int AVG_PW    = SUM_W + AVG_MW;

    localparam logic signed [CONF_W-1:0] CONF_MAX  = CONF_W'(LEVEL_CONFIRM);
    localparam logic signed [CONF_W-1:0] CONF_MIN  = CONF_W'(-LEVEL_CONFIRM);
    localparam logic signed [CONF_W-1:0] CONF_STEP = CONF_W'(1);

    function automatic logic [TW-1:0] inc_sat(input logic [TW-1:0] t);
        return (t == '1) ? t : t + TW'(1);
    endfunction

    logic [TW-1:0]            level_timer_reg, level_timer_next;
    logic signed [CONF_W-1:0] level_confirm_reg, level_confirm_next;
    logic                     water_flag_reg, water_flag_next;
    logic                     lock_flag_reg, lock_flag_next;
    logic                     pump_flag_reg, pump_flag_next;
    logic [DW-1:0]            pump_elapsed_reg, pump_elapsed_next;
    logic [TW-1:0]            pump_check_timer_reg, pump_check_timer_next;
    logic [DRY_W-1:0]         dry_count_reg, dry_count_next;
    ipc_pkg::phase_t          phase_reg, phase_next;
    logic [TW-1:0]            phase_timer_reg, phase_timer_next;
    logic                     first_cycle_reg, first_cycle_next;
    logic [SC_W-1:0]          sample_count_reg, sample_count_next;
    logic [SC_W-1:0]          below_count_reg, below_count_next;
    logic [SUM_W-1:0]         humidity_sum_reg, humidity_sum_next;
    ipc_pkg::event_t          last_event_reg, last_event_next;
    logic [TW-1:0]            dedup_timer_reg, dedup_timer_next;
    logic [HW-1:0]            last_average_reg, last_average_next;

    logic [TW-1:0]     dedup_raw;
    logic [DRY_W-1:0]  dry_inc;
    logic              stopped;
    logic              emit_on;
    ipc_pkg::event_t   emit_req;
    ipc_pkg::event_t   event_next;
    logic              avg_valid_next;
    logic [31:0]       water_wide;
    logic [AVG_PW-1:0] avg_prod;

    assign water_wide = 32'(water);
    assign dry_inc    = dry_count_reg + DRY_W'(1);
    assign dedup_raw  = inc_sat(dedup_timer_reg);

    always_comb
    begin
        level_timer_next      = inc_sat(level_timer_reg);
        phase_timer_next      = inc_sat(phase_timer_reg);
        dedup_timer_next      = dedup_raw;
        level_confirm_next    = level_confirm_reg;
        water_flag_next       = water_flag_reg;
        lock_flag_next        = lock_flag_reg;
        pump_flag_next        = pump_flag_reg;
        pump_elapsed_next     = pump_elapsed_reg;
        pump_check_timer_next = pump_check_timer_reg;
        dry_count_next        = dry_count_reg;
        phase_next            = phase_reg;
        first_cycle_next      = first_cycle_reg;
        sample_count_next     = sample_count_reg;
        below_count_next      = below_count_reg;
        humidity_sum_next     = humidity_sum_reg;
        last_event_next       = last_event_reg;
        event_next            = ipc_pkg::EV_NONE;
        emit_on               = 1'b0;
        emit_req              = ipc_pkg::EV_NONE;
        stopped               = 1'b0;
        avg_valid_next        = 1'b0;

        // water level confirm with dead band
        if (level_timer_next >= cfg.level_check_ms)
        begin
            level_timer_next = '0;
            if (water_wide < ipc_pkg::WATER_PRESENT_BELOW)
            begin
                if (level_confirm_next < 0)
                    level_confirm_next = '0;
                if (level_confirm_next < CONF_MAX)
                    level_confirm_next = level_confirm_next + CONF_STEP;
                if (level_confirm_next >= CONF_MAX)
                    water_flag_next = 1'b1;
            end
            else if (water_wide > ipc_pkg::WATER_ABSENT_ABOVE)
            begin
                if (level_confirm_next > 0)
                    level_confirm_next = '0;
                if (level_confirm_next > CONF_MIN)
                    level_confirm_next = level_confirm_next - CONF_STEP;
                if (level_confirm_next <= CONF_MIN)
                    water_flag_next = 1'b0;
            end
            if (!water_flag_next)
                lock_flag_next = 1'b1;
            if (!water_flag_reg && water_flag_next)
                lock_flag_next = 1'b0;
        end

        if (pump_flag_reg)
        begin
            pump_check_timer_next = inc_sat(pump_check_timer_reg);
            pump_elapsed_next = (pump_elapsed_reg == '1) ? pump_elapsed_reg
                                                         : pump_elapsed_reg + DW'(1);
            if (pump_check_timer_next >= cfg.level_check_ms)
            begin
                pump_check_timer_next = '0;
                if (water_wide > ipc_pkg::WATER_ABSENT_ABOVE)
                begin
                    if (dry_inc >= DRY_W'(DRY_CONFIRM))
                    begin
                        dry_count_next = '0;
                        pump_flag_next = 1'b0;
                        lock_flag_next = 1'b1;
                        emit_on        = 1'b1;
                        emit_req       = ipc_pkg::EV_OFF_DRY;
                        stopped        = 1'b1;
                    end
                    else
                    begin
                        dry_count_next = dry_inc;
                    end
                end
                else
                begin
                    dry_count_next = '0;
                end
            end
            if (!stopped && pump_elapsed_next >= cfg.pump_duration_ms)
            begin
                dry_count_next = '0;
                pump_flag_next = 1'b0;
                emit_on        = 1'b1;
                emit_req       = ipc_pkg::EV_OFF_DONE;
            end
        end
        else
        begin
            // power up, warm up, then sample; zero intervals fall straight through
            if (phase_next == ipc_pkg::PH_IDLE &&
                (first_cycle_reg || phase_timer_next >= cfg.cycle_interval_ms))
            begin
                first_cycle_next  = 1'b0;
                phase_next        = ipc_pkg::PH_WARM;
                phase_timer_next  = '0;
                sample_count_next = '0;
                below_count_next  = '0;
                humidity_sum_next = '0;
            end
            if (phase_next == ipc_pkg::PH_WARM && phase_timer_next >= cfg.warmup_ms)
            begin
                phase_next       = ipc_pkg::PH_SAMPLE;
                phase_timer_next = '0;
            end
            if (phase_next == ipc_pkg::PH_SAMPLE &&
                phase_timer_next >= cfg.sample_interval_ms)
            begin
                phase_timer_next  = '0;
                humidity_sum_next = humidity_sum_next + SUM_W'(percent);
                if (percent < cfg.humidity_threshold)
                    below_count_next = below_count_next + SC_W'(1);
                sample_count_next = sample_count_next + SC_W'(1);
                if (sample_count_next >= SC_W'(SAMPLES_PER_CYCLE))
                begin
                    avg_valid_next = 1'b1;
                    phase_next     = ipc_pkg::PH_IDLE;
                    if (below_count_next == SC_W'(SAMPLES_PER_CYCLE))
                    begin
                        emit_on = 1'b1;
                        if (!lock_flag_next && water_flag_next)
                        begin
                            dry_count_next        = '0;
                            pump_check_timer_next = '0;
                            pump_elapsed_next     = '0;
                            pump_flag_next        = 1'b1;
                            emit_req              = ipc_pkg::EV_PUMP_ON;
                        end
                        else if (!lock_flag_next)
                        begin
                            emit_req = ipc_pkg::EV_PUMP_ON;
                        end
                        else
                        begin
                            emit_req = ipc_pkg::EV_BLOCKED;
                        end
                    end
                end
            end
        end

        // repeat of the last event is dropped during the cooldown
        if (emit_on)
        begin
            if (!(emit_req == last_event_reg && dedup_raw < cfg.event_holdoff_ms))
            begin
                event_next       = emit_req;
                last_event_next  = emit_req;
                dedup_timer_next = '0;
            end
        end
    end

    // mean of the cycle by reciprocal multiply
    assign avg_prod = AVG_PW'(humidity_sum_next) * AVG_PW'(AVG_MULT);

    always_comb
    begin
        last_average_next = avg_valid_next ? avg_prod[AVG_SHIFT +: HW] : last_average_reg;
    end

    always_comb
    begin
        result.pump_drive      = pump_flag_next;
        result.sensor_power    = (phase_next != ipc_pkg::PH_IDLE);
        result.water_ok        = water_flag_next;
        result.watering_locked = lock_flag_next;
        result.event_code      = event_next;
        result.avg_valid       = avg_valid_next;
        result.humidity_avg    = last_average_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_timer_reg      <= '0;
            level_confirm_reg    <= '0;
            water_flag_reg       <= 1'b0;
            lock_flag_reg        <= 1'b1;
            pump_flag_reg        <= 1'b0;
            pump_elapsed_reg     <= '0;
            pump_check_timer_reg <= '0;
            dry_count_reg        <= '0;
            phase_reg            <= ipc_pkg::PH_IDLE;
            phase_timer_reg      <= '0;
            first_cycle_reg      <= 1'b1;
            sample_count_reg     <= '0;
            below_count_reg      <= '0;
            humidity_sum_reg     <= '0;
            last_event_reg       <= ipc_pkg::EV_NONE;
            dedup_timer_reg      <= '0;
            last_average_reg     <= '0;
        end
        else if (step)
        begin
            level_timer_reg      <= level_timer_next;
            level_confirm_reg    <= level_confirm_next;
            water_flag_reg       <= water_flag_next;
            lock_flag_reg        <= lock_flag_next;
            pump_flag_reg        <= pump_flag_next;
            pump_elapsed_reg     <= pump_elapsed_next;
            pump_check_timer_reg <= pump_check_timer_next;
            dry_count_reg        <= dry_count_next;
            phase_reg            <= phase_next;
            phase_timer_reg      <= phase_timer_next;
            first_cycle_reg      <= first_cycle_next;
            sample_count_reg     <= sample_count_next;
            below_count_reg      <= below_count_next;
            humidity_sum_reg     <= humidity_sum_next;
            last_event_reg       <= last_event_next;
            dedup_timer_reg      <= dedup_timer_next;
            last_average_reg     <= last_average_next;
        end
    end

endmodule

@@ design/irrigation_pump_controller.sv @@
// top level of the irrigation pump controller: handshakes, registers, datapath
// depends on ipc_pkg, ipc_percent and ipc_core
//
// Each request carries one millisecond tick with the water-level and soil readings and
// produces exactly one result. A new request is taken on every clock cycle unless a
// stalled result holds the flow: the soil reading is scaled to percent (one constant
// multiply) into an input register, the controller state then advances by one tick
// while the result lands in the output register, and the sustained rate is one tick
// per cycle while results are taken. The rate is set by the tick update between the
// input and the result register (counter compares plus the constant multiply for the
// cycle mean). The output register holds a result until it is taken, while an empty
// input register still accepts one more request. Registers are written through the
// plain write port and must only be written while no tick is in flight.
module irrigation_pump_controller #(
    parameter int SAMPLES_PER_CYCLE = ipc_pkg::SAMPLES_PER_CYCLE_DEF,
    parameter int LEVEL_CONFIRM     = ipc_pkg::LEVEL_CONFIRM_DEF,
    parameter int DRY_CONFIRM       = ipc_pkg::DRY_CONFIRM_DEF,
    parameter int ADC_BITS          = ipc_pkg::ADC_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [ipc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ipc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [ADC_BITS-1:0]            water_adc,
    input  logic [ADC_BITS-1:0]            soil_adc,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic                           pump_drive,
    output logic                           sensor_power,
    output logic                           water_ok,
    output logic                           watering_locked,
    output logic [2:0]                     event_code,
    output logic                           avg_valid,
    output logic [ipc_pkg::HUM_W-1:0]      humidity_avg
);

    ipc_pkg::cfg_t    cfg_reg;
    logic             s1_valid_reg;
    logic [ADC_BITS-1:0]       s1_water_reg;
    logic [ipc_pkg::HUM_W-1:0] s1_percent_reg;
    logic [ipc_pkg::HUM_W-1:0] percent_in;
    logic             result_valid_reg;
    ipc_pkg::result_t result_reg;
    ipc_pkg::result_t result_next;
    logic             advance;
    logic             item_take;

    assign advance    = s1_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !s1_valid_reg || advance;
    assign item_take  = item_valid && item_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.humidity_threshold <= ipc_pkg::THRESHOLD_RST;
            cfg_reg.pump_duration_ms   <= ipc_pkg::DURATION_RST;
            cfg_reg.cycle_interval_ms  <= ipc_pkg::CYCLE_RST;
            cfg_reg.sample_interval_ms <= ipc_pkg::SAMPLE_RST;
            cfg_reg.warmup_ms          <= ipc_pkg::WARMUP_RST;
            cfg_reg.level_check_ms     <= ipc_pkg::LEVEL_RST;
            cfg_reg.event_holdoff_ms   <= ipc_pkg::DEDUP_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ipc_pkg::REG_HUMIDITY_THRESHOLD:
                    cfg_reg.humidity_threshold <= cfg_data[ipc_pkg::HUM_W-1:0];
                ipc_pkg::REG_PUMP_DURATION:
                    cfg_reg.pump_duration_ms <= cfg_data[ipc_pkg::DUR_W-1:0];
                ipc_pkg::REG_CYCLE_INTERVAL:
                    cfg_reg.cycle_interval_ms <= cfg_data[ipc_pkg::TMR_W-1:0];
                ipc_pkg::REG_SAMPLE_INTERVAL:
                    cfg_reg.sample_interval_ms <= cfg_data[ipc_pkg::TMR_W-1:0];
                ipc_pkg::REG_WARMUP:
                    cfg_reg.warmup_ms <= cfg_data[ipc_pkg::TMR_W-1:0];
                ipc_pkg::REG_LEVEL_CHECK:
                    cfg_reg.level_check_ms <= cfg_data[ipc_pkg::TMR_W-1:0];
                ipc_pkg::REG_EVENT_DEDUP:
                    cfg_reg.event_holdoff_ms <= cfg_data[ipc_pkg::TMR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ipc_percent #(
        .ADC_BITS (ADC_BITS)
    ) u_percent (
        .soil    (soil_adc),
        .percent (percent_in)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (item_take)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_water_reg   <= water_adc;
            s1_percent_reg <= percent_in;
        end
    end

    ipc_core #(
        .SAMPLES_PER_CYCLE (SAMPLES_PER_CYCLE),
        .LEVEL_CONFIRM     (LEVEL_CONFIRM),
        .DRY_CONFIRM       (DRY_CONFIRM),
        .ADC_BITS          (ADC_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .cfg     (cfg_reg),
        .water   (s1_water_reg),
        .percent (s1_percent_reg),
        .result  (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result_valid    = result_valid_reg;
    assign pump_drive      = result_reg.pump_drive;
    assign sensor_power    = result_reg.sensor_power;
    assign water_ok        = result_reg.water_ok;
    assign watering_locked = result_reg.watering_locked;
    assign event_code      = result_reg.event_code;
    assign avg_valid       = result_reg.avg_valid;
    assign humidity_avg    = result_reg.humidity_avg;

endmodule

@@ design/ipc_checker.sv @@
// port-level checks for the irrigation pump controller, bound to the top level
// depends on ipc_pkg and irrigation_pump_controller_defines.svh
`include "irrigation_pump_controller_defines.svh"

module ipc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      item_ready,
    input logic                      result_valid,
    input logic                      result_ready,
    input logic                      pump_drive,
    input logic                      sensor_power,
    input logic                      water_ok,
    input logic                      watering_locked,
    input logic [2:0]                event_code,
    input logic                      avg_valid,
    input logic [ipc_pkg::HUM_W-1:0] humidity_avg
);

    // a stalled result keeps its payload
    `IPC_ASSERT_NXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(pump_drive) && $stable(sensor_power) && $stable(water_ok) && $stable(watering_locked) && $stable(event_code) && $stable(avg_valid) && $stable(humidity_avg))

    // an empty output register never back-pressures the input
    `IPC_ASSERT_IMP(a_ready_when_empty, clk, rst_n, !result_valid, item_ready)

    // a finished cycle or a running pump leaves the sensor unpowered
    `IPC_ASSERT_IMP(a_sensor_off, clk, rst_n, result_valid && (avg_valid || pump_drive), !sensor_power)

    // start and blocked events only come out at the end of a sampling cycle
    `IPC_ASSERT_IMP(a_start_at_cycle_end, clk, rst_n, result_valid && (event_code == ipc_pkg::EV_PUMP_ON || event_code == ipc_pkg::EV_BLOCKED), avg_valid)

    // stop events leave the pump off
    `IPC_ASSERT_IMP(a_stop_pump_off, clk, rst_n, result_valid && (event_code == ipc_pkg::EV_OFF_DRY || event_code == ipc_pkg::EV_OFF_DONE), !pump_drive)

endmodule

bind irrigation_pump_controller ipc_checker u_ipc_checker (.*);
